// ----- sv/assert_macros.svh -----
// Assertion helpers used by skpf_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define SKPF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Same, but also checked during reset
`define SKPF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ----- sv/skpf_pkg.sv -----
// ----------------------------------------------------------------------------
// skpf_pkg
// Types, constants and fixed-point helpers of the pilot Kalman filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skpf_pkg;

  localparam int DataW     = 32;
  localparam int FracW     = 16;
  localparam int MaxPilots = 16;
  localparam int PilotAw   = $clog2(MaxPilots);
  localparam int QuoW      = DataW + FracW;
  localparam int DivCntW   = $clog2(QuoW);
  localparam int NumRegs   = 6;
  localparam int AddrW     = 5;

  // register indexes
  localparam logic [2:0] RegCoefF  = 3'd0;
  localparam logic [2:0] RegCoefG  = 3'd1;
  localparam logic [2:0] RegCoefH  = 3'd2;
  localparam logic [2:0] RegProcN  = 3'd3;
  localparam logic [2:0] RegMeasN  = 3'd4;
  localparam logic [2:0] RegInitCv = 3'd5;

  typedef logic signed [DataW-1:0] val_t;

  typedef struct packed {
    val_t        coef_f;
    val_t        coef_g;
    val_t        coef_h;
    logic [30:0] process_noise;
    logic [30:0] measure_noise;
    logic [30:0] initial_cov;
  } cfg_t;

  typedef struct packed {
    logic [3:0]         pilot_index;
    logic [PilotAw-1:0] slot;
    val_t               measurement;
    logic               first_symbol;
    val_t               initial_estimate;
  } item_t;

  // clamp a magnitude to the signed range with the given sign
  function automatic val_t limit(input logic neg, input logic [QuoW-1:0] q);
    logic [DataW-1:0] r;
    r = q[DataW-1:0];
    if (neg) begin
      limit = (q > QuoW'({1'b1, {(DataW-1){1'b0}}})) ? {1'b1, {(DataW-1){1'b0}}} : -r;
    end else begin
      limit = (q > QuoW'({1'b0, {(DataW-1){1'b1}}})) ? {1'b0, {(DataW-1){1'b1}}} : r;
    end
  endfunction

  // Q16.16 product, rounded half away from zero, saturated
  function automatic val_t mulq(input val_t a, input val_t b);
    logic signed [2*DataW-1:0] prod;
    logic [2*DataW-1:0]        mg;
    logic [2*DataW-1:0]        rnd;
    prod = a * b;
    mg   = prod[2*DataW-1] ? -prod : prod;
    rnd  = (mg + (2*DataW)'(1 << (FracW-1))) >> FracW;
    mulq = limit(a[DataW-1] ^ b[DataW-1], rnd[QuoW-1:0]);
  endfunction

  // saturate a grown sum to the signed range
  function automatic val_t sat(input logic signed [DataW:0] v);
    if (v > $signed({2'b00, {(DataW-1){1'b1}}})) begin
      sat = {1'b0, {(DataW-1){1'b1}}};
    end else if (v < $signed({2'b11, {(DataW-1){1'b0}}})) begin
      sat = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      sat = v[DataW-1:0];
    end
  endfunction

  // saturate a grown sum to [0, max]
  function automatic val_t satcov(input logic signed [DataW:0] v);
    if (v[DataW]) begin
      satcov = '0;
    end else if (v[DataW-1]) begin
      satcov = {1'b0, {(DataW-1){1'b1}}};
    end else begin
      satcov = v[DataW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/skpf_front.sv -----
// ----------------------------------------------------------------------------
// skpf_front
// Accepts items, works out the store slot and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skpf_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [3:0]            pilot_index_i,
  input  wire logic signed [31:0]    measurement_i,
  input  wire logic                  first_symbol_i,
  input  wire logic signed [31:0]    initial_estimate_i,
  output logic                       item_valid_o,
  output skpf_pkg::item_t            item_o,
  input  wire logic                  item_pop_i
);

  skpf_pkg::item_t q_mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            push, pop;
  skpf_pkg::item_t new_item;

  // classify: slot of the store for this pilot
  always_comb begin
    new_item.pilot_index      = pilot_index_i;
    new_item.slot             = skpf_pkg::PilotAw'(pilot_index_i % skpf_pkg::MaxPilots);
    new_item.measurement      = measurement_i;
    new_item.first_symbol     = first_symbol_i;
    new_item.initial_estimate = initial_estimate_i;
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i & in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_pop_i & item_valid_o;
  assign item_o       = q_mem_q[rd_ptr_q];

  // two-entry queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= new_item;
  end

endmodule

`default_nettype wire

// ----- sv/skpf_back.sv -----
// ----------------------------------------------------------------------------
// skpf_back
// Sequencer with one shared Q16.16 multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skpf_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire skpf_pkg::cfg_t       cfg_i,
  input  wire logic                 item_valid_i,
  input  wire skpf_pkg::item_t      item_i,
  output logic                      item_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [31:0]        filtered_estimate_o,
  output logic signed [31:0]        predicted_measurement_o,
  output logic [30:0]               error_covariance_o,
  output logic [3:0]                pilot_index_out_o,
  output logic                      zero_denominator_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_XP, S_YH, S_T1, S_T2, S_T3, S_T4, S_P, S_T5, S_T6,
    S_DEN, S_PH, S_DIV, S_ERR, S_T7, S_XF, S_T8, S_T9, S_QN, S_OUT
  } state_e;

  state_e             state_q;
  skpf_pkg::item_t    it_q;
  skpf_pkg::val_t     x_q, q_q, xp_q, yh_q, p_q, den_q, ta_q, tb_q, gain_q, xf_q, qn_q;
  logic               zero_q, neg_q;
  logic [skpf_pkg::QuoW-1:0]    num_q, quo_q;
  logic [skpf_pkg::DataW-1:0]   rem_q;
  logic [skpf_pkg::DivCntW-1:0] dcnt_q;
  skpf_pkg::val_t     est_q [skpf_pkg::MaxPilots];
  skpf_pkg::val_t     cov_q [skpf_pkg::MaxPilots];

  skpf_pkg::val_t     opa, opb, m, qn_d, r1, r2;
  logic [skpf_pkg::DataW:0]     r_try;
  logic               bit_d;
  logic [skpf_pkg::DataW-1:0]   m_mag;

  assign r1 = {1'b0, cfg_i.process_noise};
  assign r2 = {1'b0, cfg_i.measure_noise};

  // operand selection for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state_q)
      S_XP:    begin opa = cfg_i.coef_f; opb = x_q;          end
      S_YH:    begin opa = cfg_i.coef_h; opb = xp_q;         end
      S_T1:    begin opa = cfg_i.coef_f; opb = q_q;          end
      S_T2:    begin opa = ta_q;         opb = cfg_i.coef_f; end
      S_T3:    begin opa = cfg_i.coef_g; opb = r1;           end
      S_T4:    begin opa = tb_q;         opb = cfg_i.coef_g; end
      S_T5:    begin opa = cfg_i.coef_h; opb = p_q;          end
      S_T6:    begin opa = ta_q;         opb = cfg_i.coef_h; end
      S_PH:    begin opa = p_q;          opb = cfg_i.coef_h; end
      S_T7:    begin opa = gain_q;       opb = ta_q;         end
      S_T8:    begin opa = gain_q;       opb = cfg_i.coef_h; end
      S_T9:    begin opa = tb_q;         opb = p_q;          end
      default: begin opa = '0;           opb = '0;           end
    endcase
  end

  assign m     = skpf_pkg::mulq(opa, opb);
  assign m_mag = m[skpf_pkg::DataW-1] ? -m : m;
  assign qn_d  = skpf_pkg::satcov({p_q[skpf_pkg::DataW-1], p_q} -
                                  {tb_q[skpf_pkg::DataW-1], tb_q});

  // restoring divider step
  assign r_try = {rem_q, num_q[skpf_pkg::QuoW-1]} - {1'b0, den_q};
  assign bit_d = ~r_try[skpf_pkg::DataW];

  assign item_pop_o = (state_q == S_IDLE) & item_valid_i;

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      // valid rises with a new result, falls once the result is taken
      out_valid_o <= (state_q == S_OUT) | (out_valid_o & ~out_ready_i);
      unique case (state_q)
        S_IDLE: if (item_valid_i) begin
          it_q    <= item_i;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          x_q     <= it_q.first_symbol ? it_q.initial_estimate : est_q[it_q.slot];
          q_q     <= it_q.first_symbol ? {1'b0, cfg_i.initial_cov} : cov_q[it_q.slot];
          state_q <= S_XP;
        end
        S_XP: begin xp_q <= m; state_q <= S_YH; end
        S_YH: begin yh_q <= m; state_q <= S_T1; end
        S_T1: begin ta_q <= m; state_q <= S_T2; end
        S_T2: begin ta_q <= m; state_q <= S_T3; end
        S_T3: begin tb_q <= m; state_q <= S_T4; end
        S_T4: begin tb_q <= m; state_q <= S_P;  end
        S_P: begin
          p_q     <= skpf_pkg::satcov({ta_q[skpf_pkg::DataW-1], ta_q} +
                                      {tb_q[skpf_pkg::DataW-1], tb_q});
          state_q <= S_T5;
        end
        S_T5: begin ta_q <= m; state_q <= S_T6; end
        S_T6: begin ta_q <= m; state_q <= S_DEN; end
        S_DEN: begin
          den_q   <= skpf_pkg::sat({ta_q[skpf_pkg::DataW-1], ta_q} +
                                   {r2[skpf_pkg::DataW-1], r2});
          state_q <= S_PH;
        end
        S_PH: begin
          // gain numerator; a non-positive denominator forces zero gain
          zero_q <= den_q[skpf_pkg::DataW-1] | (den_q == '0);
          neg_q  <= m[skpf_pkg::DataW-1];
          num_q  <= {m_mag, {skpf_pkg::FracW{1'b0}}};
          rem_q  <= '0;
          dcnt_q <= '0;
          gain_q <= '0;
          state_q <= (den_q[skpf_pkg::DataW-1] | (den_q == '0)) ? S_ERR : S_DIV;
        end
        S_DIV: begin
          rem_q  <= bit_d ? r_try[skpf_pkg::DataW-1:0]
                          : {rem_q[skpf_pkg::DataW-2:0], num_q[skpf_pkg::QuoW-1]};
          num_q  <= {num_q[skpf_pkg::QuoW-2:0], 1'b0};
          quo_q  <= {quo_q[skpf_pkg::QuoW-2:0], bit_d};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == skpf_pkg::DivCntW'(skpf_pkg::QuoW - 1)) begin
            gain_q  <= skpf_pkg::limit(neg_q, {quo_q[skpf_pkg::QuoW-2:0], bit_d});
            state_q <= S_ERR;
          end
        end
        S_ERR: begin
          ta_q    <= skpf_pkg::sat({it_q.measurement[skpf_pkg::DataW-1], it_q.measurement} -
                                   {yh_q[skpf_pkg::DataW-1], yh_q});
          state_q <= S_T7;
        end
        S_T7: begin ta_q <= m; state_q <= S_XF; end
        S_XF: begin
          xf_q    <= skpf_pkg::sat({xp_q[skpf_pkg::DataW-1], xp_q} +
                                   {ta_q[skpf_pkg::DataW-1], ta_q});
          state_q <= S_T8;
        end
        S_T8: begin tb_q <= m; state_q <= S_T9; end
        S_T9: begin tb_q <= m; state_q <= S_QN; end
        S_QN: begin qn_q <= qn_d; state_q <= S_OUT; end
        S_OUT: if (!out_valid_o || out_ready_i) begin
          filtered_estimate_o     <= xf_q;
          predicted_measurement_o <= yh_q;
          error_covariance_o      <= qn_q[30:0];
          pilot_index_out_o       <= it_q.pilot_index;
          zero_denominator_o      <= zero_q;
          state_q                 <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // per-pilot estimate and covariance stores
  always_ff @(posedge clk_i) begin
    if (state_q == S_QN) begin
      est_q[it_q.slot] <= xf_q;
      cov_q[it_q.slot] <= qn_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/scalar_kalman_pilot_filter_unit.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_pilot_filter_unit
// Per-pilot scalar Kalman filter, signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | pilot index, measurement, first, x0
//  out     | output    | out_valid/out_ready| estimate, prediction, cov, index, flag
//  apb     | input     | psel/penable/pready| six coefficient registers
//
// The gain divider is bit-serial, one quotient bit per cycle over its 48-bit
// quotient; it is skipped when the gain denominator is not positive.
// A two-entry queue takes items while the sequencer works; a finished result
// waits in the output register without holding the queue.
// Reset restores the registers; the pilot stores are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_pilot_filter_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [3:0]                 pilot_index_i,
  input  wire logic signed [31:0]         measurement_i,
  input  wire logic                       first_symbol_i,
  input  wire logic signed [31:0]         initial_estimate_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [31:0]              filtered_estimate_o,
  output logic signed [31:0]              predicted_measurement_o,
  output logic [30:0]                     error_covariance_o,
  output logic [3:0]                      pilot_index_out_o,
  output logic                            zero_denominator_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [skpf_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  skpf_pkg::cfg_t  cfg_q;
  skpf_pkg::item_t item;
  logic            item_valid, item_pop;
  logic [2:0]      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_f        <= 32'sd65536;
      cfg_q.coef_g        <= 32'sd65536;
      cfg_q.coef_h        <= 32'sd65536;
      cfg_q.process_noise <= 31'd655;
      cfg_q.measure_noise <= 31'd655;
      cfg_q.initial_cov   <= 31'd65536;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        skpf_pkg::RegCoefF:  cfg_q.coef_f        <= pwdata;
        skpf_pkg::RegCoefG:  cfg_q.coef_g        <= pwdata;
        skpf_pkg::RegCoefH:  cfg_q.coef_h        <= pwdata;
        skpf_pkg::RegProcN:  cfg_q.process_noise <= pwdata[30:0];
        skpf_pkg::RegMeasN:  cfg_q.measure_noise <= pwdata[30:0];
        skpf_pkg::RegInitCv: cfg_q.initial_cov   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      skpf_pkg::RegCoefF:  prdata = cfg_q.coef_f;
      skpf_pkg::RegCoefG:  prdata = cfg_q.coef_g;
      skpf_pkg::RegCoefH:  prdata = cfg_q.coef_h;
      skpf_pkg::RegProcN:  prdata = {1'b0, cfg_q.process_noise};
      skpf_pkg::RegMeasN:  prdata = {1'b0, cfg_q.measure_noise};
      skpf_pkg::RegInitCv: prdata = {1'b0, cfg_q.initial_cov};
      default:             prdata = '0;
    endcase
  end

  skpf_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .pilot_index_i      (pilot_index_i),
    .measurement_i      (measurement_i),
    .first_symbol_i     (first_symbol_i),
    .initial_estimate_i (initial_estimate_i),
    .item_valid_o       (item_valid),
    .item_o             (item),
    .item_pop_i         (item_pop)
  );

  skpf_back u_back (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_i                   (cfg_q),
    .item_valid_i            (item_valid),
    .item_i                  (item),
    .item_pop_o              (item_pop),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .filtered_estimate_o     (filtered_estimate_o),
    .predicted_measurement_o (predicted_measurement_o),
    .error_covariance_o      (error_covariance_o),
    .pilot_index_out_o       (pilot_index_out_o),
    .zero_denominator_o      (zero_denominator_o)
  );

endmodule

`default_nettype wire

// ----- sv/skpf_checker.sv -----
// ----------------------------------------------------------------------------
// skpf_checker
// Port-level checks of the pilot filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module skpf_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [31:0] filtered_estimate_o
);

  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_q + {2'b00, in_acc} - {2'b00, out_acc};
    end
  end

  `SKPF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
  `SKPF_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(filtered_estimate_o))
  `SKPF_ASSERT(a_no_spurious, clk_i, rst_ni, out_valid_o |-> pend_q != 3'd0)
  `SKPF_ASSERT(a_bounded, clk_i, rst_ni, pend_q <= 3'd4)
  `SKPF_ASSERT(a_stall_full, clk_i, rst_ni, !in_ready_o |-> pend_q >= 3'd2)

endmodule

bind scalar_kalman_pilot_filter_unit skpf_checker u_skpf_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .filtered_estimate_o (filtered_estimate_o)
);

`default_nettype wire

// ----- test/kalman_checker.sv -----
// ----------------------------------------------------------------------------
// kalman_checker
// Watches the item, result and register channels of the pilot Kalman filter,
// predicts every result in Q16.16 and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kalman_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [3:0]                 pilot_index_i,
  input  logic signed [31:0]         measurement_i,
  input  logic                       first_symbol_i,
  input  logic signed [31:0]         initial_estimate_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic signed [31:0]         filtered_estimate_i,
  input  logic signed [31:0]         predicted_measurement_i,
  input  logic [30:0]                error_covariance_i,
  input  logic [3:0]                 pilot_index_out_i,
  input  logic                       zero_denominator_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [skpf_pkg::AddrW-1:0] paddr_i,
  input  logic [31:0]                pwdata_i,
  input  logic                       pready_i,
  output int                         errors_o,
  output int                         pending_o
);

  localparam longint VMax = 64'sd2147483647;
  localparam longint VMin = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] estimate;
    logic signed [31:0] prediction;
    logic [30:0]        covariance;
    logic [3:0]         pilot;
    logic               zero_den;
  } kalman_result_t;

  kalman_result_t pending_results[$];

  // filter coefficients and per-pilot state
  longint f_q, g_q, h_q, r1_q, r2_q, q0_q;
  longint est_mem[skpf_pkg::MaxPilots];
  longint cov_mem[skpf_pkg::MaxPilots];

  function automatic longint clip(input longint v);
    return (v > VMax) ? VMax : ((v < VMin) ? VMin : v);
  endfunction

  function automatic longint clip_cov(input longint v);
    return (v < 0) ? 0 : ((v > VMax) ? VMax : v);
  endfunction

  function automatic longint sign_limit(input bit neg, input longint q);
    longint lim;
    lim = neg ? VMax + 1 : VMax;
    if (q > lim) q = lim;
    return neg ? -q : q;
  endfunction

  // rounded half away from zero, products fit in 64 bits at this width
  function automatic longint qmul(input longint a, input longint b);
    longint prod;
    prod = a * b;
    if (prod < 0) prod = -prod;
    return sign_limit((a < 0) != (b < 0), (prod + 32768) >> 16);
  endfunction

  function automatic longint qdiv(input longint num, input longint den);
    longint m;
    m = (num < 0) ? -num : num;
    return sign_limit(num < 0, (m << 16) / den);
  endfunction

  // one time and measurement update; updates the pilot state
  function automatic kalman_result_t filter_update(input logic [3:0] pilot,
      input logic signed [31:0] y_in, input logic first, input logic signed [31:0] x0);
    kalman_result_t r;
    longint x, q, xp, yhat, p, den, gain, xf, qn, y;
    y = y_in;
    gain = 0;
    if (first) begin
      x = x0;
      q = q0_q;
    end else begin
      x = est_mem[pilot];
      q = cov_mem[pilot];
    end
    q = clip_cov(q);
    xp = qmul(f_q, x);
    yhat = qmul(h_q, xp);
    p = clip_cov(qmul(qmul(f_q, q), f_q) + qmul(qmul(g_q, r1_q), g_q));
    den = clip(qmul(qmul(h_q, p), h_q) + r2_q);
    r.zero_den = (den <= 0);
    if (!r.zero_den) gain = qdiv(qmul(p, h_q), den);
    xf = clip(xp + qmul(gain, clip(y - yhat)));
    qn = clip_cov(p - qmul(qmul(gain, h_q), p));
    est_mem[pilot] = xf;
    cov_mem[pilot] = qn;
    r.estimate   = xf[31:0];
    r.prediction = yhat[31:0];
    r.covariance = qn[30:0];
    r.pilot      = pilot;
    return r;
  endfunction

  assign pending_o = pending_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    kalman_result_t e;
    if (!rst_ni) begin
      f_q  <= 65536;
      g_q  <= 65536;
      h_q  <= 65536;
      r1_q <= 655;
      r2_q <= 655;
      q0_q <= 65536;
      errors_o <= 0;
    end else begin
      // register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          skpf_pkg::RegCoefF:  f_q  <= longint'($signed(pwdata_i));
          skpf_pkg::RegCoefG:  g_q  <= longint'($signed(pwdata_i));
          skpf_pkg::RegCoefH:  h_q  <= longint'($signed(pwdata_i));
          skpf_pkg::RegProcN:  r1_q <= longint'({1'b0, pwdata_i[30:0]});
          skpf_pkg::RegMeasN:  r2_q <= longint'({1'b0, pwdata_i[30:0]});
          skpf_pkg::RegInitCv: q0_q <= longint'({1'b0, pwdata_i[30:0]});
          default: ;
        endcase
      end
      // compare a result with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding");
          errors_o <= errors_o + 1;
        end else begin
          e = pending_results.pop_front();
          if (filtered_estimate_i !== e.estimate ||
              predicted_measurement_i !== e.prediction ||
              error_covariance_i !== e.covariance ||
              pilot_index_out_i !== e.pilot ||
              zero_denominator_i !== e.zero_den)
            errors_o <= errors_o + 1;
          if (filtered_estimate_i !== e.estimate)
            $error("filtered_estimate exp %0d got %0d", e.estimate, filtered_estimate_i);
          if (predicted_measurement_i !== e.prediction)
            $error("predicted_measurement exp %0d got %0d", e.prediction,
                   predicted_measurement_i);
          if (error_covariance_i !== e.covariance)
            $error("error_covariance exp %0d got %0d", e.covariance, error_covariance_i);
          if (pilot_index_out_i !== e.pilot)
            $error("pilot_index_out exp %0d got %0d", e.pilot, pilot_index_out_i);
          if (zero_denominator_i !== e.zero_den)
            $error("zero_denominator exp %0d got %0d", e.zero_den, zero_denominator_i);
        end
      end
      // predict each accepted item
      if (in_valid_i && in_ready_i)
        pending_results.push_back(filter_update(pilot_index_i, measurement_i,
                                                first_symbol_i, initial_estimate_i));
    end
  end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the pilot Kalman filter with directed and random items under a
// series of coefficient settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // index past the register list, must be ignored
  localparam logic [2:0] RegUnused = 3'd6;
  localparam logic [31:0] QMax = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin = 32'h8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] pilot = '0;
  logic signed [31:0] meas = '0;
  logic first = 1'b0;
  logic signed [31:0] x0 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] est_o, pred_o;
  logic [30:0] cov_o;
  logic [3:0] pilot_o;
  logic zden_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [skpf_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors, outstanding;
  bit calm = 1'b0;
  bit seen[16];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scalar_kalman_pilot_filter_unit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .pilot_index_i(pilot), .measurement_i(meas), .first_symbol_i(first),
    .initial_estimate_i(x0),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .filtered_estimate_o(est_o), .predicted_measurement_o(pred_o),
    .error_covariance_o(cov_o), .pilot_index_out_o(pilot_o), .zero_denominator_o(zden_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  kalman_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .pilot_index_i(pilot), .measurement_i(meas), .first_symbol_i(first),
    .initial_estimate_i(x0),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .filtered_estimate_i(est_o), .predicted_measurement_i(pred_o),
    .error_covariance_i(cov_o), .pilot_index_out_i(pilot_o), .zero_denominator_i(zden_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .errors_o(errors), .pending_o(outstanding)
  );

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 36);
  end

  // one item; an optional gap first, then hold until accepted
  task automatic push_item(input logic [3:0] p, input logic signed [31:0] y,
                           input logic fs, input logic signed [31:0] xi);
    if (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    pilot <= p;
    meas  <= y;
    first <= fs;
    x0    <= xi;
    in_valid <= 1'b1;
    seen[p] = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // setup and access cycle; the caller ends the transfer sequence
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  // drain, then write the whole register set
  task automatic load_coefs(input logic [31:0] f, input logic [31:0] g,
      input logic [31:0] h, input logic [31:0] r1, input logic [31:0] r2,
      input logic [31:0] q0);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    reg_write(skpf_pkg::RegCoefF, f);
    reg_write(skpf_pkg::RegCoefG, g);
    reg_write(skpf_pkg::RegCoefH, h);
    reg_write(skpf_pkg::RegProcN, r1);
    reg_write(skpf_pkg::RegMeasN, r2);
    reg_write(skpf_pkg::RegInitCv, q0);
    reg_write(RegUnused, $urandom);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? QMax : QMin;
      2: return '0;
      default: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
    endcase
  endfunction

  // coefficient from -0.5 to 1.5 in Q16.16, drawn at random
  function automatic logic [31:0] near_one();
    return 32'($signed($urandom_range(1 << 17)) - (1 << 15));
  endfunction

  initial begin
    logic [3:0] p;
    logic fs;
    logic signed [31:0] y;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients, field extremes
    push_item(4'd0, QMin, 1'b1, QMax);
    push_item(4'd15, QMax, 1'b1, QMin);
    push_item(4'd0, 32'sd0, 1'b0, QMin);
    push_item(4'd15, -32'sd1, 1'b0, 32'sd0);
    push_item(4'd7, 32'sd65536, 1'b1, 32'sd0);
    push_item(4'd7, 32'sd65536, 1'b0, QMax);
    // zero gain denominator: H and R2 both zero
    load_coefs(32'd65536, 32'd65536, 32'd0, 32'd655, 32'h8000_0000, 32'd65536);
    push_item(4'd0, 32'sd1000, 1'b0, 32'sd0);
    push_item(4'd3, QMax, 1'b1, 32'sd70000);
    push_item(4'd3, QMin, 1'b0, 32'sd0);
    // upper extremes, but G and H at their lower extremes
    load_coefs(QMax, QMin, QMin, QMax, QMax, QMax);
    push_item(4'd15, QMax, 1'b1, QMax);
    push_item(4'd0, QMin, 1'b0, QMin);
    push_item(4'd9, 32'sd0, 1'b1, QMin);
    // F low, H high, the rest zero; a fresh covariance collapses to zero
    load_coefs(QMin, 32'd0, QMax, 32'd0, 32'd0, 32'd0);
    push_item(4'd9, QMax, 1'b0, 32'sd0);
    push_item(4'd12, QMin, 1'b1, QMax);
    push_item(4'd12, 32'sd12345, 1'b0, 32'sd0);

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 4 == 3)
        load_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        load_coefs(near_one() + 32'd49152, near_one(), near_one() + 32'd49152,
                   {1'($urandom_range(1)), 31'($urandom_range(1 << 16))},
                   {1'($urandom_range(1)), 31'($urandom_range(1 << 16))},
                   {1'($urandom_range(1)), 31'($urandom_range(1 << 18))});
      calm = (ph == 4);
      for (int n = 0; n < 225; n++) begin
        p = 4'($urandom_range(15));
        fs = !seen[p] || ($urandom_range(9) == 0);
        y = ($urandom_range(9) == 0) ? rand_value() :
            32'($signed($urandom_range(1 << 19)) - (1 << 18));
        push_item(p, y, fs, rand_value());
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
